// ===== hdl/ace_pkg.sv =====
package ace_pkg;

    localparam int DEF_CHANNELS      = 4;
    localparam int DEF_CAPTURE_DEPTH = 4096;
    localparam int DEF_BLOCK_FRAMES  = 25;

    localparam int RAW_BITS    = 24;
    localparam int ACC_W       = 32;
    localparam int VALUE_W     = 32;
    localparam int SLOPE_W     = 32;
    localparam int DONE_W      = 13;
    localparam int COUNT_W     = 16;
    localparam int INDEX_W     = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int SCALE_SHIFT = 24;
    localparam int OUTQ_DEPTH  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_DBMA_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DBMA_SLOPE  = 2'd1;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_START  = 2'd1,
        OP_STOP   = 2'd2,
        OP_READ   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_WAIT,
        SEQ_READ,
        SEQ_DRAIN
    } t_seq_state;

    typedef struct packed {
        logic [1:0]                 opcode;
        logic [1:0]                 channel;
        logic signed [RAW_BITS-1:0] sample_code;
        logic [COUNT_W-1:0]         start_count;
        logic [INDEX_W-1:0]         read_index;
    } t_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] point_value;
        logic                      point_valid;
        logic [DONE_W-1:0]         points_done;
        logic                      capture_active;
    } t_result;

endpackage

// ===== hdl/ace_ram.sv =====
module ace_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ace_conv.sv =====
module ace_conv import ace_pkg::*; #(
    parameter int SUM_W        = 29,
    parameter int CH_AW        = 2,
    parameter int BLOCK_FRAMES = DEF_BLOCK_FRAMES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  logic [CH_AW-1:0]          i_ch,
    input  logic signed [SUM_W-1:0]   i_sum,
    input  logic signed [VALUE_W-1:0] i_offset,
    input  logic [SLOPE_W-1:0]        i_slope,
    output logic                      o_busy,
    output logic                      o_wr_vld,
    output logic [CH_AW-1:0]          o_wr_ch,
    output logic signed [VALUE_W-1:0] o_value
);

    localparam int DIV_L   = $clog2(BLOCK_FRAMES);
    localparam int DIV_SH  = SUM_W + DIV_L;
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int SC_W    = SUM_W + SLOPE_W;
    localparam int Q_W     = SC_W + 1 - SCALE_SHIFT;
    localparam int R_W     = Q_W + 1;
    localparam logic [63:0] DIV_POW = 64'd1 << DIV_SH;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((DIV_POW + 64'(BLOCK_FRAMES) - 64'd1) / 64'(BLOCK_FRAMES));
    localparam logic [SC_W:0] ROUND_UP = (SC_W+1)'((64'd1 << SCALE_SHIFT) - 64'd1);

    logic              r1_vld, r2_vld, r3_vld, r4_vld;
    logic [CH_AW-1:0]  r1_ch, r2_ch, r3_ch, r4_ch;
    logic              r1_neg, r2_neg, r3_neg;
    logic [SUM_W-1:0]  r1_mag;
    logic [PROD_W-1:0] r2_prod;
    logic [SC_W-1:0]   r3_scaled;
    logic signed [VALUE_W-1:0] r4_value;

    logic [SUM_W-1:0]       w_avg;
    logic [SC_W:0]          w_round;
    logic [Q_W-1:0]         w_q;
    logic signed [R_W-1:0]  w_off_ext;
    logic signed [R_W-1:0]  w_q_ext;
    logic signed [R_W-1:0]  w_diff;
    logic                   w_ovf;
    logic signed [VALUE_W-1:0] w_sat;

    assign w_avg = SUM_W'(r2_prod >> DIV_SH);

    always_comb begin
        w_round   = r3_neg ? ((SC_W+1)'(r3_scaled) + ROUND_UP) : (SC_W+1)'(r3_scaled);
        w_q       = Q_W'(w_round >> SCALE_SHIFT);
        w_off_ext = R_W'(i_offset);
        w_q_ext   = R_W'(w_q);
        w_diff    = r3_neg ? (w_off_ext + w_q_ext) : (w_off_ext - w_q_ext);
        w_ovf     = !(&w_diff[R_W-1:VALUE_W-1]) && (|w_diff[R_W-1:VALUE_W-1]);
        if (w_ovf) begin
            w_sat = w_diff[R_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                  : {1'b0, {(VALUE_W-1){1'b1}}};
        end else begin
            w_sat = w_diff[VALUE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_ch     <= i_ch;
        r1_neg    <= i_sum[SUM_W-1];
        r1_mag    <= i_sum[SUM_W-1] ? SUM_W'(-i_sum) : SUM_W'(i_sum);
        r2_ch     <= r1_ch;
        r2_neg    <= r1_neg;
        r2_prod   <= PROD_W'(r1_mag) * PROD_W'(RECIP);
        r3_ch     <= r2_ch;
        r3_neg    <= r2_neg;
        r3_scaled <= SC_W'(w_avg) * SC_W'(i_slope);
        r4_ch     <= r3_ch;
        r4_value  <= w_sat;
    end

    assign o_busy   = i_vld | r1_vld | r2_vld | r3_vld | r4_vld;
    assign o_wr_vld = r4_vld;
    assign o_wr_ch  = r4_ch;
    assign o_value  = r4_value;

endmodule

// ===== hdl/averaging_capture_engine.sv =====
// A result is registered with its store data, then written into the result queue.
// Throughput: one item per cycle while the result queue has room and no block
// close is running; the four-entry queue lets input run on while results wait.
// An item that closes a block holds off input while the sum memory is swept.
// Reset (i_rst_n low, synchronous) clears control, counters and both registers;
// the point store is not cleared and is readable only where written.
module averaging_capture_engine import ace_pkg::*; #(
    parameter int CHANNELS      = DEF_CHANNELS,
    parameter int CAPTURE_DEPTH = DEF_CAPTURE_DEPTH,
    parameter int BLOCK_FRAMES  = DEF_BLOCK_FRAMES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_item                i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_result              o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [VALUE_W-1:0]   i_cfg_data
);

    localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int FR_W     = $clog2(BLOCK_FRAMES + 1);
    localparam int CNT_W    = $clog2(CAPTURE_DEPTH + 1);
    localparam int SUM_W    = ACC_W;
    localparam int ST_DEPTH = CAPTURE_DEPTH * CHANNELS;
    localparam int ST_AW    = $clog2(ST_DEPTH);
    localparam int QP_W     = $clog2(OUTQ_DEPTH);
    localparam int QC_W     = $clog2(OUTQ_DEPTH + 1);

    logic signed [VALUE_W-1:0] r_offset;
    logic [SLOPE_W-1:0]        r_slope;

    logic              r_active, n_active;
    logic [CNT_W-1:0]  r_done, n_done;
    logic [CNT_W-1:0]  r_target, n_target;
    logic [FR_W-1:0]   r_frames, n_frames;
    logic [FR_W-1:0]   w_frames_inc;

    logic w_accept;
    logic w_ch_ok, w_ch_last;
    logic w_acc_en, w_fin, w_fin_wr, w_sum_clr, w_rd_ok;

    logic                    r_b_vld;
    logic [CH_AW-1:0]        r_b_ch;
    logic signed [SUM_W-1:0] r_b_raw;
    logic                    r_fwd_hit;
    logic signed [SUM_W-1:0] r_fwd_sum;
    logic signed [SUM_W-1:0] w_b_old, w_b_new;
    logic [CHANNELS-1:0]     r_sum_vld, n_sum_vld;

    logic                    w_sum_re;
    logic [CH_AW-1:0]        w_sum_raddr;
    logic [SUM_W-1:0]        w_sum_rdata;

    t_seq_state              r_seq, n_seq;
    logic [CH_AW-1:0]        r_rd_ch, n_rd_ch;
    logic                    w_seq_rd, w_seq_done, w_seq_busy;
    logic                    r_fin_wr;
    logic [ST_AW-1:0]        r_fin_base;
    logic                    r_sq_pend, r_sq_vld;
    logic [CH_AW-1:0]        r_sq_ch;
    logic signed [SUM_W-1:0] w_sq_sum;

    logic                      w_conv_busy, w_conv_vld;
    logic [CH_AW-1:0]          w_conv_ch;
    logic signed [VALUE_W-1:0] w_conv_value;

    logic                w_st_we, w_st_re;
    logic [ST_AW-1:0]    w_st_waddr, w_st_raddr;
    logic [VALUE_W-1:0]  w_st_rdata;

    logic       r_p_vld, r_p_rd;
    t_result    r_p, w_p_item;

    t_result           r_q [OUTQ_DEPTH];
    logic [QP_W-1:0]   r_wp, r_rp;
    logic [QC_W-1:0]   r_cnt;
    logic              w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_slope  <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_DBMA_OFFSET) begin
                r_offset <= signed'(i_cfg_data);
            end
            if (i_cfg_index == CFG_DBMA_SLOPE) begin
                r_slope <= i_cfg_data;
            end
        end
    end

    assign w_seq_busy = (r_seq != SEQ_IDLE);
    assign o_ready    = !w_seq_busy && ((int'(r_cnt) + int'(r_p_vld)) < OUTQ_DEPTH);
    assign w_accept   = i_valid && o_ready;

    assign w_ch_ok      = int'(i_item.channel) < CHANNELS;
    assign w_ch_last    = int'(i_item.channel) == (CHANNELS - 1);
    assign w_frames_inc = FR_W'(r_frames + 1'b1);

    always_comb begin
        n_active  = r_active;
        n_done    = r_done;
        n_target  = r_target;
        n_frames  = r_frames;
        w_acc_en  = 1'b0;
        w_fin     = 1'b0;
        w_fin_wr  = 1'b0;
        w_sum_clr = 1'b0;
        w_rd_ok   = 1'b0;
        if (w_accept) begin
            case (i_item.opcode)
                OP_SAMPLE: begin
                    if (r_active && w_ch_ok) begin
                        w_acc_en = 1'b1;
                        if (w_ch_last) begin
                            n_frames = w_frames_inc;
                            if (int'(w_frames_inc) >= BLOCK_FRAMES) begin
                                w_fin    = 1'b1;
                                n_frames = '0;
                                if (r_done < r_target && int'(r_done) < CAPTURE_DEPTH) begin
                                    w_fin_wr = 1'b1;
                                    n_done   = CNT_W'(r_done + 1'b1);
                                end
                                if (n_done >= r_target) begin
                                    n_active = 1'b0;
                                end
                            end
                        end
                    end
                end
                OP_START: begin
                    if (i_item.start_count != '0) begin
                        n_target  = (int'(i_item.start_count) > CAPTURE_DEPTH) ?
                                    CNT_W'(CAPTURE_DEPTH) : CNT_W'(i_item.start_count);
                        n_done    = '0;
                        n_frames  = '0;
                        n_active  = 1'b1;
                        w_sum_clr = 1'b1;
                    end
                end
                OP_STOP: begin
                    n_active = 1'b0;
                end
                OP_READ: begin
                    w_rd_ok = w_ch_ok && (int'(i_item.read_index) < int'(r_done))
                              && (int'(i_item.read_index) < CAPTURE_DEPTH);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= '0;
            r_target <= '0;
            r_frames <= '0;
        end else begin
            r_active <= n_active;
            r_done   <= n_done;
            r_target <= n_target;
            r_frames <= n_frames;
        end
    end

    // accumulate: read at accept, add and write back in the cycle after
    always_comb begin
        if (r_fwd_hit) begin
            w_b_old = r_fwd_sum;
        end else if (r_sum_vld[r_b_ch]) begin
            w_b_old = signed'(w_sum_rdata);
        end else begin
            w_b_old = '0;
        end
        w_b_new = w_b_old + r_b_raw;
    end

    always_comb begin
        n_sum_vld = r_sum_vld;
        if (r_b_vld) begin
            n_sum_vld[r_b_ch] = 1'b1;
        end
        if (w_sum_clr || w_seq_done) begin
            n_sum_vld = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld   <= 1'b0;
            r_fwd_hit <= 1'b0;
            r_sum_vld <= '0;
        end else begin
            r_b_vld   <= w_acc_en;
            r_fwd_hit <= w_acc_en && r_b_vld && (CH_AW'(i_item.channel) == r_b_ch);
            r_sum_vld <= n_sum_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_ch    <= CH_AW'(i_item.channel);
        r_b_raw   <= SUM_W'(i_item.sample_code);
        r_fwd_sum <= w_b_new;
    end

    assign w_sum_re    = w_seq_rd || w_acc_en;
    assign w_sum_raddr = w_seq_rd ? r_rd_ch : CH_AW'(i_item.channel);

    ace_ram #(
        .WIDTH (SUM_W),
        .DEPTH (CHANNELS)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (r_b_vld),
        .i_waddr (r_b_ch),
        .i_wdata (w_b_new),
        .i_re    (w_sum_re),
        .i_raddr (w_sum_raddr),
        .o_rdata (w_sum_rdata)
    );

    // block close: sweep the sum memory through the converter
    always_comb begin
        n_seq = r_seq;
        case (r_seq)
            SEQ_IDLE: begin
                if (w_fin) begin
                    n_seq = SEQ_WAIT;
                end
            end
            SEQ_WAIT: begin
                n_seq = SEQ_READ;
            end
            SEQ_READ: begin
                if (int'(r_rd_ch) == (CHANNELS - 1)) begin
                    n_seq = SEQ_DRAIN;
                end
            end
            SEQ_DRAIN: begin
                if (!w_conv_busy) begin
                    n_seq = SEQ_IDLE;
                end
            end
            default: begin
                n_seq = SEQ_IDLE;
            end
        endcase
    end

    always_comb begin
        w_seq_rd   = 1'b0;
        w_seq_done = 1'b0;
        n_rd_ch    = '0;
        case (r_seq)
            SEQ_READ: begin
                w_seq_rd = 1'b1;
                n_rd_ch  = CH_AW'(r_rd_ch + 1'b1);
            end
            SEQ_DRAIN: begin
                w_seq_done = !w_conv_busy;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq     <= SEQ_IDLE;
            r_rd_ch   <= '0;
            r_sq_pend <= 1'b0;
            r_fin_wr  <= 1'b0;
        end else begin
            r_seq     <= n_seq;
            r_rd_ch   <= n_rd_ch;
            r_sq_pend <= w_seq_rd;
            if (w_fin) begin
                r_fin_wr <= w_fin_wr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_ch  <= r_rd_ch;
        r_sq_vld <= r_sum_vld[r_rd_ch];
        if (w_fin) begin
            r_fin_base <= ST_AW'(int'(r_done) * CHANNELS);
        end
    end

    assign w_sq_sum = r_sq_vld ? signed'(w_sum_rdata) : '0;

    ace_conv #(
        .SUM_W        (SUM_W),
        .CH_AW        (CH_AW),
        .BLOCK_FRAMES (BLOCK_FRAMES)
    ) u_conv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (r_sq_pend),
        .i_ch     (r_sq_ch),
        .i_sum    (w_sq_sum),
        .i_offset (r_offset),
        .i_slope  (r_slope),
        .o_busy   (w_conv_busy),
        .o_wr_vld (w_conv_vld),
        .o_wr_ch  (w_conv_ch),
        .o_value  (w_conv_value)
    );

    assign w_st_we    = w_conv_vld && r_fin_wr;
    assign w_st_waddr = ST_AW'(r_fin_base + ST_AW'(w_conv_ch));
    assign w_st_re    = w_accept && (i_item.opcode == OP_READ);
    assign w_st_raddr = ST_AW'(int'(i_item.read_index) * CHANNELS + int'(i_item.channel));

    ace_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (ST_DEPTH)
    ) u_point_ram (
        .i_clk   (i_clk),
        .i_we    (w_st_we),
        .i_waddr (w_st_waddr),
        .i_wdata (w_conv_value),
        .i_re    (w_st_re),
        .i_raddr (w_st_raddr),
        .o_rdata (w_st_rdata)
    );

    // result: register alongside the store read data, then queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_rd               <= w_rd_ok;
        r_p.point_value      <= '0;
        r_p.point_valid      <= w_rd_ok;
        r_p.points_done      <= DONE_W'(n_done);
        r_p.capture_active   <= n_active;
    end

    always_comb begin
        w_p_item = r_p;
        w_p_item.point_value = r_p_rd ? signed'(w_st_rdata) : '0;
    end

    assign o_valid  = (r_cnt != '0);
    assign o_result = r_q[r_rp];
    assign w_pop    = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (r_p_vld) begin
                r_wp <= QP_W'(r_wp + 1'b1);
            end
            if (w_pop) begin
                r_rp <= QP_W'(r_rp + 1'b1);
            end
            r_cnt <= QC_W'(r_cnt + QC_W'(r_p_vld) - QC_W'(w_pop));
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p_vld) begin
            r_q[r_wp] <= w_p_item;
        end
    end

    a_seq_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq != SEQ_IDLE) |-> !o_ready)
        else $error("item accepted during block close");

    a_close_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin |=> (r_seq == SEQ_WAIT))
        else $error("block close did not start sweep");

    a_active_below_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_done < r_target))
        else $error("capture active with target reached");

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_cnt) + int'(r_p_vld)) <= OUTQ_DEPTH)
        else $error("result queue overflow");

    a_store_write_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_st_we |-> (r_seq == SEQ_READ || r_seq == SEQ_DRAIN))
        else $error("point store written outside sweep");

endmodule
